>>> rtl/sidt_pkg.sv
// Package for the sorted insert/delete table: request codes, result status codes,
// sequencer state type and the structs passed between the top level and the cells.
// No dependencies.
package sidt_pkg;

    localparam int ValW = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CMP,
        SEQ_UPD,
        SEQ_RES
    } seq_state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             shift_ins;
        logic             shift_del;
        logic [1:0]       action;
        logic [ValW-1:0]  value;
    } cell_cmd_t;

    // registered compare flags a cell shows its upper neighbour
    typedef struct packed {
        logic occ;
        logic gt;
        logic ge;
        logic eq;
    } cell_link_t;

endpackage

>>> rtl/sidt_cell.sv
// One slot of the sorted table: holds an entry, compares it with the broadcast
// value and moves data to and from its neighbours. Depends on sidt_pkg.
module sidt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                        aclk,
    input  sidt_pkg::cell_cmd_t         cmd,
    input  logic [CW-1:0]               count,
    input  sidt_pkg::cell_link_t        prev_link,
    input  logic [sidt_pkg::ValW-1:0]   prev_entry,
    input  logic [sidt_pkg::ValW-1:0]   next_entry,
    output sidt_pkg::cell_link_t        link,
    output logic [sidt_pkg::ValW-1:0]   entry,
    output logic                        hit,
    output logic [sidt_pkg::ValW-1:0]   last_val
);

    localparam logic [CW-1:0] IDX_C  = CW'(IDX);
    localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);
    localparam logic          FIRST  = (IDX == 0);

    logic [sidt_pkg::ValW-1:0] entry_reg;
    logic [sidt_pkg::ValW-1:0] entry_next;
    sidt_pkg::cell_link_t      link_reg;
    sidt_pkg::cell_link_t      link_next;
    logic                      hit_ins;
    logic                      hit_del;
    logic                      occ;

    assign occ = (count > IDX_C);

    always_comb begin
        link_next = link_reg;
        if (cmd.cmp_en) begin
            link_next.occ = occ;
            link_next.gt  = occ && ($signed(entry_reg) > $signed(cmd.value));
            link_next.ge  = occ && ($signed(entry_reg) >= $signed(cmd.value));
            link_next.eq  = occ && (entry_reg == cmd.value);
        end
    end

    // sorted order makes the insert point and first match local edges
    assign hit_ins = !prev_link.gt &&
                     (link_reg.gt || (!link_reg.occ && (FIRST || prev_link.occ)));
    assign hit_del = link_reg.eq && !prev_link.eq;
    assign hit     = (cmd.action == sidt_pkg::ACT_INSERT) ? hit_ins : hit_del;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.shift_ins) begin
            if (prev_link.gt) begin
                entry_next = prev_entry;
            end else if (hit_ins) begin
                entry_next = cmd.value;
            end
        end else if (cmd.shift_del && link_reg.ge) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        link_reg  <= link_next;
    end

    assign link     = link_reg;
    assign entry    = entry_reg;
    assign last_val = (count == IDX_P1) ? entry_reg : '0;

endmodule

>>> rtl/sorted_insert_delete_table.sv
// Sorted insert/delete table. Holds up to CAPACITY signed 32-bit values in
// ascending order in a row of cells, one value per cell. A request passes
// through the CMP, UPD and RES states from acceptance to a loaded result:
// every cell compares the registered value with its entry, the cells shift up
// or down by one slot while the slot position is gathered, and the result with
// count, smallest, largest and empty flag is built from the updated row. The
// row is one shared unit, so one request is in flight at a time; s_tready rises
// again in the cycle after the result register is loaded, even while that
// result waits on m_tready. No clearing pass is needed after reset; only slots
// below the fill count are ever read.
// Depends on sidt_pkg and sidt_cell.
module sorted_insert_delete_table #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[1:0], value[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status[1:0], position[7:2], fill_count[14:8],
                                   // smallest[46:15], largest[78:47], empty_res[79]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(CAPACITY);
    localparam int VW = sidt_pkg::ValW;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    sidt_pkg::seq_state_t state_reg, state_next;

    logic [1:0]    act_reg;
    logic [VW-1:0] val_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    status_reg, status_next;
    logic [SW-1:0] pos_reg, pos_next;
    logic          m_valid_reg, m_valid_next;
    logic [79:0]   m_data_reg;

    logic          accept;
    logic          load_out;
    logic          full;
    sidt_pkg::cell_cmd_t cmd;

    sidt_pkg::cell_link_t link   [CAPACITY];
    logic [VW-1:0]        entry  [CAPACITY];
    logic [VW-1:0]        last_v [CAPACITY];
    logic [CAPACITY-1:0]  hit;

    logic [SW-1:0] hit_pos;
    logic          found;
    logic [VW-1:0] largest;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            sidt_pkg::cell_link_t prev_link;
            logic [VW-1:0]        prev_entry;
            logic [VW-1:0]        next_entry;

            if (gi == 0) begin : g_lo
                assign prev_link  = '0;
                assign prev_entry = '0;
            end else begin : g_mid
                assign prev_link  = link[gi-1];
                assign prev_entry = entry[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_hi
                assign next_entry = entry[gi];
            end else begin : g_nx
                assign next_entry = entry[gi+1];
            end

            sidt_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .count      (count_reg),
                .prev_link  (prev_link),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .link       (link[gi]),
                .entry      (entry[gi]),
                .hit        (hit[gi]),
                .last_val   (last_v[gi])
            );
        end
    endgenerate

    // at most one cell raises hit, so OR-ing indices gives its slot
    always_comb begin
        hit_pos = '0;
        found   = 1'b0;
        largest = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hit[i]) begin
                hit_pos = hit_pos | SW'(i);
            end
            found   = found | hit[i];
            largest = largest | last_v[i];
        end
    end

    assign full = (count_reg >= CAP_C);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sidt_pkg::SEQ_IDLE: if (s_tvalid) state_next = sidt_pkg::SEQ_CMP;
            sidt_pkg::SEQ_CMP:  state_next = sidt_pkg::SEQ_UPD;
            sidt_pkg::SEQ_UPD:  state_next = sidt_pkg::SEQ_RES;
            sidt_pkg::SEQ_RES:  if (!m_valid_reg || m_tready) state_next = sidt_pkg::SEQ_IDLE;
            default:            state_next = sidt_pkg::SEQ_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready      = 1'b0;
        load_out      = 1'b0;
        cmd.cmp_en    = 1'b0;
        cmd.shift_ins = 1'b0;
        cmd.shift_del = 1'b0;
        cmd.action    = act_reg;
        cmd.value     = val_reg;
        case (state_reg)
            sidt_pkg::SEQ_IDLE: s_tready = 1'b1;
            sidt_pkg::SEQ_CMP:  cmd.cmp_en = 1'b1;
            sidt_pkg::SEQ_UPD: begin
                cmd.shift_ins = (act_reg == sidt_pkg::ACT_INSERT) && !full;
                cmd.shift_del = (act_reg == sidt_pkg::ACT_DELETE) && found;
            end
            sidt_pkg::SEQ_RES:  load_out = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        if (state_reg == sidt_pkg::SEQ_UPD) begin
            status_next = sidt_pkg::ST_DONE;
            pos_next    = '0;
            case (act_reg)
                sidt_pkg::ACT_INSERT: begin
                    if (full) begin
                        status_next = sidt_pkg::ST_FULL;
                    end else begin
                        pos_next   = hit_pos;
                        count_next = count_reg + ONE_C;
                    end
                end
                sidt_pkg::ACT_DELETE: begin
                    if (found) begin
                        pos_next   = hit_pos;
                        count_next = count_reg - ONE_C;
                    end else begin
                        status_next = sidt_pkg::ST_MISSING;
                    end
                end
                sidt_pkg::ACT_SEARCH: begin
                    if (found) begin
                        pos_next = hit_pos;
                    end else begin
                        status_next = sidt_pkg::ST_MISSING;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sidt_pkg::SEQ_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        pos_reg    <= pos_next;
        if (accept) begin
            act_reg <= s_tdata[1:0];
            val_reg <= s_tdata[33:2];
        end
        if (load_out) begin
            m_data_reg[1:0]   <= status_reg;
            m_data_reg[7:2]   <= 6'(pos_reg);
            m_data_reg[14:8]  <= 7'(count_reg);
            m_data_reg[46:15] <= (count_reg == '0) ? '0 : entry[0];
            m_data_reg[78:47] <= largest;
            m_data_reg[79]    <= (count_reg == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_insert_delete_table: a queue-fed stream driver,
// an in-bench model of the sorted table, and a result monitor with a scoreboard.
// Depends on sidt_pkg and the table RTL.
module tb;

    localparam int TAB_DEPTH = 64;
    localparam int POOL_N = 24;
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS = 100;
    localparam logic [1:0] ACT_NOP = 2'd3;   // unused code, table left alone

    typedef struct {
        logic [1:0]  action;
        logic [31:0] value;
        int          idle_pct;
        int          stall_pct;
    } table_req_t;

    typedef struct {
        logic [1:0]         status;
        logic [5:0]         position;
        logic [6:0]         fill_count;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
        logic               empty_res;
    } table_result_t;

    typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIX, BURST_NOISE} burst_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    table_req_t    pending_q[$];
    table_result_t expected_q[$];
    table_req_t    offered;

    // shadow of the sorted row
    logic signed [31:0] shadow_tab[TAB_DEPTH];
    int                 shadow_fill = 0;

    logic [31:0] value_pool[POOL_N];
    int          rcv_stall_pct = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          err_cnt = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    sorted_insert_delete_table #(
        .CAPACITY(TAB_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic table_result_t apply_request(input logic [1:0] act,
                                                    input logic signed [31:0] val);
        table_result_t r;
        int slot;
        r.status = sidt_pkg::ST_DONE;
        slot = 0;
        case (act)
            sidt_pkg::ACT_INSERT: begin
                if (shadow_fill >= TAB_DEPTH) begin
                    r.status = sidt_pkg::ST_FULL;
                end else begin
                    // goes after any equal entries
                    slot = shadow_fill;
                    for (int i = 0; i < shadow_fill; i++) begin
                        if (shadow_tab[i] > val) begin
                            slot = i;
                            break;
                        end
                    end
                    for (int i = shadow_fill; i > slot; i--)
                        shadow_tab[i] = shadow_tab[i - 1];
                    shadow_tab[slot] = val;
                    shadow_fill++;
                end
            end
            sidt_pkg::ACT_DELETE, sidt_pkg::ACT_SEARCH: begin
                slot = -1;
                for (int i = 0; i < shadow_fill; i++) begin
                    if (shadow_tab[i] == val) begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0) begin
                    r.status = sidt_pkg::ST_MISSING;
                    slot = 0;
                end else if (act == sidt_pkg::ACT_DELETE) begin
                    for (int i = slot; i + 1 < shadow_fill; i++)
                        shadow_tab[i] = shadow_tab[i + 1];
                    shadow_fill--;
                end
            end
            default: ;
        endcase
        r.position = 6'(slot);
        r.fill_count = 7'(shadow_fill);
        r.empty_res = (shadow_fill == 0);
        r.smallest = r.empty_res ? 32'sd0 : shadow_tab[0];
        r.largest = r.empty_res ? 32'sd0 : shadow_tab[shadow_fill - 1];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        // keep the log bounded on a badly broken build
        if (err_cnt <= MAX_PRINTS)
            $display("%0t ns: result %0d: %s", $time, n_results, msg);
    endtask

    task automatic check_result(input logic [79:0] d);
        table_result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unrequested result %h", d));
            return;
        end
        want = expected_q.pop_front();
        if (d[1:0] != want.status)
            report_mismatch($sformatf("status exp %0d got %0d", want.status, d[1:0]));
        if (d[7:2] != want.position)
            report_mismatch($sformatf("position exp %0d got %0d", want.position, d[7:2]));
        if (d[14:8] != want.fill_count)
            report_mismatch($sformatf("fill_count exp %0d got %0d",
                                      want.fill_count, d[14:8]));
        if (d[46:15] != want.smallest)
            report_mismatch($sformatf("smallest exp %h got %h", want.smallest, d[46:15]));
        if (d[78:47] != want.largest)
            report_mismatch($sformatf("largest exp %h got %h", want.largest, d[78:47]));
        if (d[79] != want.empty_res)
            report_mismatch($sformatf("empty_res exp %0b got %0b", want.empty_res, d[79]));
        n_results++;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 70)
            return value_pool[$urandom_range(POOL_N - 1)];
        return $urandom;
    endfunction

    task automatic add_req(input logic [1:0] act, input logic [31:0] val,
                           input int idle, input int stall);
        table_req_t t;
        t.action = act;
        t.value = val;
        t.idle_pct = idle;
        t.stall_pct = stall;
        pending_q.push_back(t);
    endtask

    // driver: a request stays on the bus until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(apply_request(offered.action, offered.value));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].idle_pct) begin
                    offered = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, offered.value, offered.action};
                    rcv_stall_pct <= offered.stall_pct;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off once, so the block backs up onto s_tready
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        logic [1:0] mix_ops[3];
        burst_t burst;
        int made;
        int len;
        logic [1:0] act;

        idle_by_phase = '{0, 76, 0, 28};
        stall_by_phase = '{0, 0, 76, 28};
        mix_ops = '{sidt_pkg::ACT_INSERT, sidt_pkg::ACT_DELETE, sidt_pkg::ACT_SEARCH};

        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h8000_0001;
        value_pool[5] = 32'h7FFF_FFFE;
        value_pool[6] = 32'h0000_0001;
        for (int i = 7; i < POOL_N; i++)
            value_pool[i] = $urandom;

        // directed: empty table, extremes, duplicates, first match, unused code
        add_req(sidt_pkg::ACT_SEARCH, 32'd5, 0, 0);
        add_req(sidt_pkg::ACT_DELETE, 32'd5, 0, 0);
        add_req(ACT_NOP, 32'd0, 0, 0);
        add_req(sidt_pkg::ACT_INSERT, 32'd0, 0, 0);
        add_req(sidt_pkg::ACT_INSERT, 32'h8000_0000, 0, 0);
        add_req(sidt_pkg::ACT_INSERT, 32'h7FFF_FFFF, 0, 0);
        add_req(sidt_pkg::ACT_INSERT, 32'd7, 0, 0);
        add_req(sidt_pkg::ACT_INSERT, 32'd7, 0, 0);
        add_req(sidt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 0, 0);
        add_req(sidt_pkg::ACT_INSERT, 32'd7, 0, 0);
        add_req(sidt_pkg::ACT_SEARCH, 32'd7, 0, 0);
        add_req(sidt_pkg::ACT_SEARCH, 32'd12345, 0, 0);
        add_req(sidt_pkg::ACT_SEARCH, 32'h8000_0000, 0, 0);
        add_req(sidt_pkg::ACT_SEARCH, 32'h7FFF_FFFF, 0, 0);
        add_req(sidt_pkg::ACT_DELETE, 32'd7, 0, 0);
        add_req(sidt_pkg::ACT_DELETE, 32'h7FFF_FFFF, 0, 0);
        add_req(sidt_pkg::ACT_DELETE, 32'h8000_0000, 0, 0);
        add_req(sidt_pkg::ACT_DELETE, 32'd99, 0, 0);
        add_req(ACT_NOP, 32'hFFFF_FFFF, 0, 0);
        add_req(sidt_pkg::ACT_INSERT, 32'h8000_0001, 0, 0);
        add_req(sidt_pkg::ACT_SEARCH, 32'hFFFF_FFFF, 0, 0);

        // random bursts: fills run past full, drains mostly hit pool values
        for (int ph = 0; ph < 4; ph++) begin
            made = 0;
            while (made < 410) begin
                burst = burst_t'($urandom_range(3));
                case (burst)
                    BURST_FILL:  len = $urandom_range(80, 70);
                    BURST_DRAIN: len = $urandom_range(80, 60);
                    BURST_MIX:   len = $urandom_range(60, 20);
                    default:     len = $urandom_range(15, 5);
                endcase
                for (int k = 0; k < len; k++) begin
                    case (burst)
                        BURST_FILL:  act = ($urandom_range(9) == 0) ?
                                           sidt_pkg::ACT_SEARCH : sidt_pkg::ACT_INSERT;
                        BURST_DRAIN: act = ($urandom_range(4) == 0) ?
                                           sidt_pkg::ACT_SEARCH : sidt_pkg::ACT_DELETE;
                        BURST_MIX:   act = mix_ops[$urandom_range(2)];
                        default:     act = 2'($urandom);
                    endcase
                    add_req(act, (burst == BURST_NOISE) ? $urandom : pick_value(),
                            idle_by_phase[ph], stall_by_phase[ph]);
                end
                made += len;
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0);
        repeat (20) @(negedge aclk);

        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sorted_insert_delete_table.f
rtl/sidt_pkg.sv
rtl/sidt_cell.sv
rtl/sorted_insert_delete_table.sv
dv/tb.sv
